>>> rtl/core/pnv_pkg.sv
// Shared types, constants and helper functions for the personal ID number validator.
`timescale 1ns / 1ps
`default_nettype none

package pnv_pkg;

    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [3:0] NUM_CHARS   = 4'd10;
    localparam logic [3:0] COUNT_MAX   = 4'd11;
    localparam logic [3:0] SUM_CHARS   = 4'd9;
    localparam logic [3:0] POS_MONTH   = 4'd2;
    localparam logic [3:0] POS_DAY     = 4'd4;
    localparam logic [3:0] POS_TAIL    = 4'd6;
    localparam logic [3:0] MOD_BASE    = 4'd11;
    localparam logic [3:0] REM_TEN     = 4'd10;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] MONTH_SHIFT = 7'd40;
    localparam logic [6:0] DAYS_31     = 7'd31;
    localparam logic [6:0] DAYS_30     = 7'd30;
    localparam logic [6:0] DAYS_29     = 7'd29;
    localparam logic [6:0] DAYS_28     = 7'd28;

    // running state after one character is absorbed
    typedef struct packed {
        logic [3:0] char_count;
        logic       all_digits;
        logic [3:0] sum_mod;
        logic [6:0] year;
        logic [6:0] month;
        logic [6:0] day;
        logic [3:0] check_digit;
    } pnv_acc_t;

    function automatic logic [3:0] pnv_weight(input logic [3:0] pos);
        logic [3:0] w;
        case (pos)
            4'd0:    w = 4'd2;
            4'd1:    w = 4'd4;
            4'd2:    w = 4'd8;
            4'd3:    w = 4'd5;
            4'd4:    w = 4'd10;
            4'd5:    w = 4'd9;
            4'd6:    w = 4'd7;
            4'd7:    w = 4'd3;
            4'd8:    w = 4'd6;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // x mod 11 for x <= 100: reciprocal 94/1024 then one correction-free subtract
    function automatic logic [3:0] pnv_mod11(input logic [6:0] x);
        logic [13:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 14'(x) * 14'd94;
        q    = prod[13:10];
        r    = x - 7'(q) * 7'(MOD_BASE);
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pnv_accum.sv
// Per-character state update: count, digit flag, checksum remainder and date fields.
`timescale 1ns / 1ps
`default_nettype none

module pnv_accum (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        character,
    input  wire logic              last,
    output pnv_pkg::pnv_acc_t      acc_next
);
    import pnv_pkg::*;

    logic [3:0] count_reg, count_next;
    logic       digits_reg, digits_next;
    logic [3:0] sum_reg, sum_next;
    logic [6:0] year_reg, year_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] day_reg, day_next;

    logic       is_digit;
    logic [7:0] char_off;
    logic [3:0] d;
    logic [7:0] prod;
    logic [6:0] dec_base;
    logic [6:0] dec_val;

    assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign char_off = character - CHAR_ZERO;
    assign d        = is_digit ? char_off[3:0] : 4'd0;
    assign prod     = 8'(d) * 8'(pnv_weight(count_reg));

    always_comb begin
        if (count_reg < POS_MONTH) begin
            dec_base = year_reg;
        end else if (count_reg < POS_DAY) begin
            dec_base = month_reg;
        end else begin
            dec_base = day_reg;
        end
    end

    assign dec_val = 7'(dec_base * 7'd10) + 7'(d);

    always_comb begin
        digits_next = digits_reg;
        sum_next    = sum_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        if (count_reg < NUM_CHARS) begin
            if (!is_digit) begin
                digits_next = 1'b0;
            end
            if (count_reg < SUM_CHARS) begin
                sum_next = pnv_mod11(7'(sum_reg) + prod[6:0]);
            end
            if (count_reg < POS_MONTH) begin
                year_next = dec_val;
            end else if (count_reg < POS_DAY) begin
                month_next = dec_val;
            end else if (count_reg < POS_TAIL) begin
                day_next = dec_val;
            end
        end
        count_next = (count_reg < COUNT_MAX) ? count_reg + 4'd1 : count_reg;
    end

    always_comb begin
        acc_next.char_count  = count_next;
        acc_next.all_digits  = digits_next;
        acc_next.sum_mod     = sum_next;
        acc_next.year        = year_next;
        acc_next.month       = month_next;
        acc_next.day         = day_next;
        acc_next.check_digit = d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 4'd0;
            digits_reg <= 1'b1;
            sum_reg    <= 4'd0;
            year_reg   <= 7'd0;
            month_reg  <= 7'd0;
            day_reg    <= 7'd0;
        end else if (step) begin
            if (last) begin
                count_reg  <= 4'd0;
                digits_reg <= 1'b1;
                sum_reg    <= 4'd0;
                year_reg   <= 7'd0;
                month_reg  <= 7'd0;
                day_reg    <= 7'd0;
            end else begin
                count_reg  <= count_next;
                digits_reg <= digits_next;
                sum_reg    <= sum_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pnv_check.sv
// Final validity test: length, digits, month, day range and check digit.
`timescale 1ns / 1ps
`default_nettype none

module pnv_check (
    input  wire pnv_pkg::pnv_acc_t acc,
    output logic                   valid_res
);
    import pnv_pkg::*;

    logic [6:0] month_eff;
    logic [6:0] month_len;
    logic [3:0] rem;

    always_comb begin
        if (acc.month > MONTH_MAX) begin
            month_eff = acc.month - MONTH_SHIFT;
        end else begin
            month_eff = acc.month;
        end
    end

    // wrapped values of raw months 13..39 land far above 12, raw 40 lands on 0; all invalid
    always_comb begin
        case (month_eff)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: month_len = DAYS_31;
            7'd4, 7'd6, 7'd9, 7'd11:                   month_len = DAYS_30;
            7'd2:    month_len = (acc.year[1:0] == 2'd0) ? DAYS_29 : DAYS_28;
            default: month_len = 7'd0;
        endcase
    end

    assign rem = (acc.sum_mod == REM_TEN) ? 4'd0 : acc.sum_mod;

    assign valid_res = (acc.char_count == NUM_CHARS) && acc.all_digits
                     && (month_len != 7'd0) && (acc.day != 7'd0)
                     && (acc.day <= month_len) && (rem == acc.check_digit);

endmodule

`default_nettype wire

>>> rtl/core/personal_id_number_validator_core.sv
// Top level of the personal ID number validator: input register, update logic, result register.
//
//   channel | direction | tdata              | tlast         | tuser
//   s_axis  | in        | [7:0] character    | end_of_string | -
//   m_axis  | out       | [0] valid_res      | -             | -
//
// One character is taken per cycle unless the result is stalled; the final character
// passes the input register and its result is then captured in the result register.
// Throughput is set by the single update step between the input and result registers.
// aresetn (synchronous, active low) clears the string state and both valid flags.
// A stalled result holds both stages; s_axis_tready drops only while both are full.
`timescale 1ns / 1ps
`default_nettype none

module personal_id_number_validator_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] character
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] valid_res, [7:1] zero
);
    import pnv_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       res_valid_reg, res_valid_next;
    logic       res_reg;

    logic       advance;
    logic       step;
    pnv_acc_t   acc_next;
    logic       check_ok;

    assign advance       = !res_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;

    pnv_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .character (in_char_reg),
        .last      (in_last_reg),
        .acc_next  (acc_next)
    );

    pnv_check u_check (
        .acc       (acc_next),
        .valid_res (check_ok)
    );

    assign res_valid_next = advance ? (step && in_last_reg) : res_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step && in_last_reg) begin
            res_reg <= check_ok;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg};

endmodule

`default_nettype wire
